FILE: hw/rtl/codepage_to_utf8_encoder_core_defines.svh
// Assertion macros used by the checker file cp2u8_checker.sv.
`ifndef CODEPAGE_TO_UTF8_ENCODER_CORE_DEFINES_SVH
`define CODEPAGE_TO_UTF8_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CP2U8_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cp2u8 assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CP2U8_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cp2u8 assertion failed");

`endif

FILE: hw/rtl/cp2u8_pkg.sv
// ----------------------------------------------------------------------------
// cp2u8_pkg
// Types and constants of the codepage to UTF-8 encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cp2u8_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
    localparam logic [15:0] CP_INVALID   = 16'hffff;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_START  = 2'd1,
        CMD_ENCODE = 2'd2,
        CMD_FINISH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  table_index;
        logic [15:0] table_value;
        logic [15:0] capacity;
        logic [7:0]  in_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [1:0]  status;
        logic        last;
        logic [15:0] encoded_length;
    } t_out_word;

    // Result words of one input, handed from the encoder to the serializer.
    typedef struct packed {
        logic                 load;
        logic [1:0]           count;
        t_out_word [2:0]      res;
    } t_seq;

endpackage

`default_nettype wire

FILE: hw/rtl/cp2u8_table.sv
// ----------------------------------------------------------------------------
// cp2u8_table
// 256 x 16 code point table, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cp2u8_table (
    input  wire logic        i_clk,
    input  wire logic        i_wr_en,
    input  wire logic [7:0]  i_wr_addr,
    input  wire logic [15:0] i_wr_data,
    input  wire logic        i_rd_en,
    input  wire logic [7:0]  i_rd_addr,
    output logic      [15:0] o_rd_data
);

    logic [15:0] r_mem [256];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hw/rtl/cp2u8_encode.sv
// ----------------------------------------------------------------------------
// cp2u8_encode
// Input register, buffer state and UTF-8 byte generation for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cp2u8_encode #(
    parameter int COUNT_BITS = cp2u8_pkg::COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire cp2u8_pkg::t_in_word i_in_word,
    input  wire logic [15:0]         i_code,
    input  wire logic                i_can_load,
    output logic                     o_in_ready,
    output cp2u8_pkg::t_seq          o_seq
);

    import cp2u8_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                  r_s1_valid;
    t_in_word              r_s1_word;
    logic [COUNT_BITS-1:0] r_space;
    logic [COUNT_BITS-1:0] r_written;
    t_status               r_err;

    logic [COUNT_BITS-1:0] n_space;
    logic [COUNT_BITS-1:0] n_written;
    t_status               n_err;

    logic                  needs_out;
    logic                  s1_adv;
    logic [1:0]            need;
    logic [2:0][7:0]       enc_bytes;
    logic [31:0]           cap32;
    t_out_word             stat_res;
    t_seq                  seq;

    function automatic logic [15:0] len16(input logic [COUNT_BITS-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[15:0];
    endfunction

    assign needs_out  = (r_s1_word.command == CMD_ENCODE) || (r_s1_word.command == CMD_FINISH);
    assign s1_adv     = r_s1_valid && (!needs_out || i_can_load);
    assign o_in_ready = !r_s1_valid || s1_adv;

    // UTF-8 forms of the looked-up code point; need of zero marks unconvertible
    always_comb begin
        enc_bytes = '0;
        if (i_code < CP_ONE_LIMIT) begin
            need         = 2'd1;
            enc_bytes[0] = i_code[7:0];
        end else if (i_code < CP_TWO_LIMIT) begin
            need         = 2'd2;
            enc_bytes[0] = {3'b110, i_code[10:6]};
            enc_bytes[1] = {2'b10, i_code[5:0]};
        end else if (i_code != CP_INVALID) begin
            need         = 2'd3;
            enc_bytes[0] = {4'b1110, i_code[15:12]};
            enc_bytes[1] = {2'b10, i_code[11:6]};
            enc_bytes[2] = {2'b10, i_code[5:0]};
        end else begin
            need = 2'd0;
        end
    end

    always_comb begin
        n_space   = r_space;
        n_written = r_written;
        n_err     = r_err;
        cap32     = 32'(r_s1_word.capacity);

        stat_res                = '0;
        stat_res.status         = r_err;
        stat_res.last           = 1'b1;
        stat_res.encoded_length = len16(r_written);

        seq       = '0;
        seq.load  = s1_adv && needs_out;

        case (r_s1_word.command)
            CMD_WRITE: begin
            end
            CMD_START: begin
                n_space   = (cap32 > 32'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(cap32);
                n_written = '0;
                n_err     = ST_OK;
            end
            CMD_ENCODE: begin
                seq.count = 2'd1;
                if (r_err != ST_OK) begin
                    seq.res[0] = stat_res;
                end else if (need == 2'd0) begin
                    n_err             = ST_INVALID;
                    seq.res[0]        = stat_res;
                    seq.res[0].status = ST_INVALID;
                end else if (r_space < COUNT_BITS'(need)) begin
                    n_err             = ST_TOO_LONG;
                    seq.res[0]        = stat_res;
                    seq.res[0].status = ST_TOO_LONG;
                end else begin
                    seq.count = need;
                    n_space   = r_space - COUNT_BITS'(need);
                    n_written = r_written + COUNT_BITS'(need);
                    for (int k = 0; k < 3; k++) begin
                        seq.res[k].out_byte       = enc_bytes[k];
                        seq.res[k].byte_valid     = 1'b1;
                        seq.res[k].status         = ST_OK;
                        seq.res[k].last           = (2'(k) == need - 2'd1);
                        seq.res[k].encoded_length =
                            len16(r_written + COUNT_BITS'(k + 1));
                    end
                end
            end
            CMD_FINISH: begin
                seq.count  = 2'd1;
                seq.res[0] = stat_res;
            end
            default: begin
            end
        endcase
    end

    assign o_seq = seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_space    <= '0;
            r_written  <= '0;
            r_err      <= ST_OK;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_space   <= n_space;
                r_written <= n_written;
                r_err     <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_word <= i_in_word;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cp2u8_emit.sv
// ----------------------------------------------------------------------------
// cp2u8_emit
// Three-slot result register that hands out one result word per cycle while i_out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cp2u8_emit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cp2u8_pkg::t_seq      i_seq,
    output logic                      o_can_load,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output cp2u8_pkg::t_out_word      o_out_word
);

    import cp2u8_pkg::*;

    logic [1:0]      r_cnt;
    t_out_word [2:0] r_slot;
    logic            pop;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_word  = r_slot[0];
    assign pop         = o_out_valid && i_out_ready;
    // refill when empty or when the last pending word leaves this cycle
    assign o_can_load  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_seq.load) begin
            r_cnt <= i_seq.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seq.load) begin
            r_slot <= i_seq.res;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/codepage_to_utf8_encoder_core.sv
// Codepage to UTF-8 encoder. Input words are table writes, buffer starts,
// encode bytes and finish requests; each goes through a one-word input
// register (the table read is registered with it) and a three-slot result
// register. Table writes and starts give no result. An encode byte gives
// one to three result words, a finish or an error gives one; the result
// register hands out one word per cycle while i_out_ready is high, and the
// next word is taken while the current one is still being sent. The first
// result passes through the input register and then the result register.
// The table has no reset; an entry must be written before a byte that maps
// to it is encoded.
// ----------------------------------------------------------------------------
// codepage_to_utf8_encoder_core
// Top level: table, encoder stage and result serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module codepage_to_utf8_encoder_core #(
    parameter int COUNT_BITS = cp2u8_pkg::COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire cp2u8_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output cp2u8_pkg::t_out_word      o_out_word
);

    import cp2u8_pkg::*;

    logic        accept;
    logic [15:0] code;
    logic        can_load;
    t_seq        seq;

    assign accept = i_in_valid && o_in_ready;

    cp2u8_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_in_word.command == CMD_WRITE)),
        .i_wr_addr (i_in_word.table_index),
        .i_wr_data (i_in_word.table_value),
        .i_rd_en   (accept && (i_in_word.command == CMD_ENCODE)),
        .i_rd_addr (i_in_word.in_byte),
        .o_rd_data (code)
    );

    cp2u8_encode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_encode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_word  (i_in_word),
        .i_code     (code),
        .i_can_load (can_load),
        .o_in_ready (o_in_ready),
        .o_seq      (seq)
    );

    cp2u8_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seq       (seq),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/cp2u8_checker.sv
// ----------------------------------------------------------------------------
// cp2u8_checker
// Port-level checks on the result channel of the encoder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "codepage_to_utf8_encoder_core_defines.svh"

module cp2u8_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire cp2u8_pkg::t_out_word o_out_word
);

    import cp2u8_pkg::*;

    logic out_pop;
    logic out_stall;

    assign out_pop   = o_out_valid && i_out_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    // stalled word holds
    `CP2U8_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_word))

    // status-only words always close their input
    `CP2U8_ASSERT_IMPL(a_stat_last, o_out_valid && !o_out_word.byte_valid, o_out_word.last)

    // data bytes carry ok status
    `CP2U8_ASSERT_IMPL(a_byte_ok, o_out_valid && o_out_word.byte_valid, o_out_word.status == ST_OK)

    // rest of a multibyte character is already queued
    `CP2U8_ASSERT_NEXT(a_seq_cont, out_pop && !o_out_word.last, o_out_valid && o_out_word.byte_valid)

endmodule

bind codepage_to_utf8_encoder_core cp2u8_checker u_checker (.*);

`default_nettype wire
